// ----- sv/spq_pkg.sv -----
// Shared types and codes for the sorted priority queue.
package spq_pkg;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // Shift commands broadcast to every cell of the chain.
  typedef struct packed {
    logic ins;  // accepted insert that finds room
    logic rem;  // accepted remove that finds an entry
  } ctl_t;

endpackage

// ----- sv/spq_cell.sv -----
// One slot of the sorted chain: holds an entry and trades it with its neighbors.
module spq_cell #(
  parameter int PAYLOAD_WIDTH = 32,
  parameter int PRIO_WIDTH    = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  spq_pkg::ctl_t            ctl_i,
  input  logic [PAYLOAD_WIDTH-1:0] new_payload_i,
  input  logic [PRIO_WIDTH-1:0]    new_prio_i,
  input  logic                     prev_ahead_i,
  input  logic                     prev_valid_i,
  input  logic [PAYLOAD_WIDTH-1:0] prev_payload_i,
  input  logic [PRIO_WIDTH-1:0]    prev_prio_i,
  input  logic                     next_valid_i,
  input  logic [PAYLOAD_WIDTH-1:0] next_payload_i,
  input  logic [PRIO_WIDTH-1:0]    next_prio_i,
  output logic                     ahead_o,
  output logic                     valid_o,
  output logic [PAYLOAD_WIDTH-1:0] payload_o,
  output logic [PRIO_WIDTH-1:0]    prio_o
);

  logic                     valid_q, valid_d;
  logic [PAYLOAD_WIDTH-1:0] payload_q, payload_d;
  logic [PRIO_WIDTH-1:0]    prio_q, prio_d;

  // An entry stays ahead of a new one when its priority is equal or greater,
  // so among equal priorities the older entry keeps the earlier slot.
  assign ahead_o = valid_q && ($signed(prio_q) >= $signed(new_prio_i));

  always_comb begin
    valid_d   = valid_q;
    payload_d = payload_q;
    prio_d    = prio_q;
    if (ctl_i.ins && !ahead_o) begin
      if (prev_ahead_i) begin
        valid_d   = 1'b1;
        payload_d = new_payload_i;
        prio_d    = new_prio_i;
      end else begin
        valid_d   = prev_valid_i;
        payload_d = prev_payload_i;
        prio_d    = prev_prio_i;
      end
    end else if (ctl_i.rem) begin
      valid_d   = next_valid_i;
      payload_d = next_payload_i;
      prio_d    = next_prio_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    payload_q <= payload_d;
    prio_q    <= prio_d;
  end

  assign valid_o   = valid_q;
  assign payload_o = payload_q;
  assign prio_o    = prio_q;

endmodule

// ----- sv/sorted_priority_queue_core.sv -----
// Sorted priority queue built as a chain of compare-and-shift cells.
// Entries are held in a row of cells ordered by descending priority, oldest
// first among equal priorities, so the head cell always holds the next entry
// to leave. An insert is compared against every cell at once and each cell
// keeps its entry, takes the new one or takes its upper neighbor's; a remove
// shifts the whole row up by one. Each item yields exactly one result in the
// cycle after it is accepted, and a new item is taken every cycle while the
// output register is empty or being drained, so the sustained rate is one
// item per cycle; the cycle time is set by one priority compare plus the
// slot selection inside a cell.
module sorted_priority_queue_core #(
  parameter int CAPACITY      = 16,
  parameter int PAYLOAD_WIDTH = 32,
  parameter int PRIO_WIDTH    = 16,
  localparam int CntW  = $clog2(CAPACITY + 1),
  localparam int InW   = ((PAYLOAD_WIDTH + PRIO_WIDTH + 7) / 8) * 8,
  localparam int OutW  = ((2 * PAYLOAD_WIDTH + PRIO_WIDTH + 1 + CntW + 7) / 8) * 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  input  logic [InW-1:0]  s_axis_tdata_i,   // payload, prio
  input  logic            s_axis_tuser_i,   // op
  output logic            m_axis_tvalid_o,
  input  logic            m_axis_tready_i,
  output logic [OutW-1:0] m_axis_tdata_o,   // removed_payload, removed_prio,
                                            // top_valid, top_payload, occupancy
  output logic [1:0]      m_axis_tuser_o    // status
);

  localparam int PrioLo = PAYLOAD_WIDTH;
  localparam int RpLo   = 0;
  localparam int RqLo   = PAYLOAD_WIDTH;
  localparam int TvLo   = PAYLOAD_WIDTH + PRIO_WIDTH;
  localparam int TpLo   = TvLo + 1;
  localparam int OcLo   = TpLo + PAYLOAD_WIDTH;

  logic                     accept;
  logic                     is_remove;
  logic [PAYLOAD_WIDTH-1:0] in_payload;
  logic [PRIO_WIDTH-1:0]    in_prio;
  spq_pkg::ctl_t            ctl;

  logic [CAPACITY-1:0]      ahead;
  logic [CAPACITY-1:0]      valid;
  logic [PAYLOAD_WIDTH-1:0] payload [CAPACITY];
  logic [PRIO_WIDTH-1:0]    prio    [CAPACITY];

  logic [CntW-1:0]          count_q, count_d;
  logic                     m_valid_q;
  logic [OutW-1:0]          m_data_q, m_data_d;
  spq_pkg::status_e         m_status_q, m_status_d;

  assign in_payload = s_axis_tdata_i[PAYLOAD_WIDTH-1:0];
  assign in_prio    = s_axis_tdata_i[PrioLo +: PRIO_WIDTH];
  assign is_remove  = (s_axis_tuser_i == spq_pkg::OP_REMOVE);

  assign s_axis_tready_o = !m_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  // The last cell is occupied exactly when the queue is full.
  assign ctl.ins = accept && !is_remove && !valid[CAPACITY-1];
  assign ctl.rem = accept && is_remove && valid[0];

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic                     p_ahead, p_valid, n_valid;
    logic [PAYLOAD_WIDTH-1:0] p_payload, n_payload;
    logic [PRIO_WIDTH-1:0]    p_prio, n_prio;

    if (g == 0) begin : g_head
      // Everything before the head counts as ahead of a new entry.
      assign p_ahead   = 1'b1;
      assign p_valid   = 1'b0;
      assign p_payload = '0;
      assign p_prio    = '0;
    end else begin : g_body
      assign p_ahead   = ahead[g-1];
      assign p_valid   = valid[g-1];
      assign p_payload = payload[g-1];
      assign p_prio    = prio[g-1];
    end

    if (g == CAPACITY - 1) begin : g_tail
      assign n_valid   = 1'b0;
      assign n_payload = '0;
      assign n_prio    = '0;
    end else begin : g_inner
      assign n_valid   = valid[g+1];
      assign n_payload = payload[g+1];
      assign n_prio    = prio[g+1];
    end

    spq_cell #(
      .PAYLOAD_WIDTH(PAYLOAD_WIDTH),
      .PRIO_WIDTH   (PRIO_WIDTH)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctl_i         (ctl),
      .new_payload_i (in_payload),
      .new_prio_i    (in_prio),
      .prev_ahead_i  (p_ahead),
      .prev_valid_i  (p_valid),
      .prev_payload_i(p_payload),
      .prev_prio_i   (p_prio),
      .next_valid_i  (n_valid),
      .next_payload_i(n_payload),
      .next_prio_i   (n_prio),
      .ahead_o       (ahead[g]),
      .valid_o       (valid[g]),
      .payload_o     (payload[g]),
      .prio_o        (prio[g])
    );
  end

  // Result fields reflect the chain as it will be after this item.
  always_comb begin
    count_d    = count_q;
    m_data_d   = '0;
    m_status_d = spq_pkg::ST_OK;
    if (is_remove) begin
      if (!valid[0]) begin
        m_status_d = spq_pkg::ST_EMPTY;
      end else begin
        count_d                         = count_q - CntW'(1);
        m_data_d[RpLo +: PAYLOAD_WIDTH] = payload[0];
        m_data_d[RqLo +: PRIO_WIDTH]    = prio[0];
        if (CAPACITY > 1 && valid[1]) begin
          m_data_d[TvLo]                  = 1'b1;
          m_data_d[TpLo +: PAYLOAD_WIDTH] = payload[1];
        end
      end
    end else begin
      m_data_d[TvLo] = 1'b1;
      if (valid[CAPACITY-1]) begin
        m_status_d                      = spq_pkg::ST_FULL;
        m_data_d[TpLo +: PAYLOAD_WIDTH] = payload[0];
      end else begin
        count_d = count_q + CntW'(1);
        if (ahead[0]) begin
          m_data_d[TpLo +: PAYLOAD_WIDTH] = payload[0];
        end else begin
          m_data_d[TpLo +: PAYLOAD_WIDTH] = in_payload;
        end
      end
    end
    m_data_d[OcLo +: CntW] = count_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q   <= count_d;
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      m_data_q   <= m_data_d;
      m_status_q <= m_status_d;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_status_q;

endmodule

// ----- sv/spq_checker.sv -----
// Port-level checks for the sorted priority queue, bound to the top level.
module spq_checker #(
  parameter int CAPACITY      = 16,
  parameter int PAYLOAD_WIDTH = 32,
  parameter int PRIO_WIDTH    = 16,
  localparam int CntW  = $clog2(CAPACITY + 1),
  localparam int OutW  = ((2 * PAYLOAD_WIDTH + PRIO_WIDTH + 1 + CntW + 7) / 8) * 8
) (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            s_axis_tvalid_i,
  input logic            s_axis_tready_o,
  input logic            m_axis_tvalid_o,
  input logic            m_axis_tready_i,
  input logic [OutW-1:0] m_axis_tdata_o,
  input logic [1:0]      m_axis_tuser_o
);

  localparam int TvLo = PAYLOAD_WIDTH + PRIO_WIDTH;
  localparam int OcLo = TvLo + 1 + PAYLOAD_WIDTH;

  logic [CntW-1:0] occ;
  logic            top_v;

  assign occ   = m_axis_tdata_o[OcLo +: CntW];
  assign top_v = m_axis_tdata_o[TvLo];

  // A result that is not taken must hold.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  // The head entry is reported exactly when the queue is not empty.
  a_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (top_v == (occ != '0)) && (occ <= CntW'(CAPACITY)))
    else $error("top flag or occupancy out of line");

  // A full report comes only from a full queue, an empty report from an empty one.
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |->
      (m_axis_tuser_o == spq_pkg::ST_OK) ||
      (m_axis_tuser_o == spq_pkg::ST_FULL && occ == CntW'(CAPACITY)) ||
      (m_axis_tuser_o == spq_pkg::ST_EMPTY && occ == '0))
    else $error("status disagrees with occupancy");

  // Every accepted item shows up as a result in the next cycle.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> m_axis_tvalid_o)
    else $error("accepted item produced no result");

endmodule

bind sorted_priority_queue_core spq_checker #(
  .CAPACITY     (CAPACITY),
  .PAYLOAD_WIDTH(PAYLOAD_WIDTH),
  .PRIO_WIDTH   (PRIO_WIDTH)
) u_spq_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .s_axis_tvalid_i(s_axis_tvalid_i),
  .s_axis_tready_o(s_axis_tready_o),
  .m_axis_tvalid_o(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_o (m_axis_tdata_o),
  .m_axis_tuser_o (m_axis_tuser_o)
);
